>>> hdl/actr_pkg.sv
// shared types, constants and aes helper functions for the ctr byte stream
package actr_pkg;

	localparam int BlockBytes = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_KEY_SIZE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_W0 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_W1 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY_W2 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KEY_W3 = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_NONCE_HI = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_NONCE_LO = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic load;   // load state, key schedule start
		logic step;   // advance one round or key word
		logic take;   // consume one keystream byte
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;   // keystream block ready
	} dp_stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// state byte i lives at bits [127-8i -: 8]
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i+4*c] = b[i + 4*((c+i) % 4)];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (!last) begin
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
		aes_round = r;
	endfunction

endpackage

>>> hdl/aes_ctr_byte_stream.sv
// top level of the aes counter-mode byte stream transformer
//
//  channel | signals                            | direction
//  input   | data_valid, data_ready, data_byte  | in
//  output  | out_valid, out_ready, out_byte     | out
//  config  | cfg_we, cfg_idx, cfg_data          | in
//
// a new keystream block is built before its first byte is taken:
// a load step, then per round four key words produced one per cycle and one
// round on a single round unit, then a step that latches the block
// after that the 16 bytes pass at one transaction per cycle while the output is not stalled
// reset (arst_n low) restarts the stream at counter zero, registers cleared
// a write to a defined register restarts the stream; a stalled output holds its byte
module aes_ctr_byte_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte
);
	logic [1:0]   key_size_q;
	logic [255:0] key_q;
	logic [127:0] nonce_q;
	logic         restart;
	actr_pkg::ctl_cmd_t cmd;
	actr_pkg::dp_stat_t stat;

	// writes beyond the last register are dropped without restart
	assign restart = cfg_we && (cfg_idx <= actr_pkg::REG_NONCE_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			key_q <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				actr_pkg::REG_KEY_SIZE: key_size_q <= cfg_data[1:0];
				actr_pkg::REG_KEY_W0:   key_q[255:192] <= cfg_data;
				actr_pkg::REG_KEY_W1:   key_q[191:128] <= cfg_data;
				actr_pkg::REG_KEY_W2:   key_q[127:64] <= cfg_data;
				actr_pkg::REG_KEY_W3:   key_q[63:0] <= cfg_data;
				actr_pkg::REG_NONCE_HI: nonce_q[127:64] <= cfg_data;
				actr_pkg::REG_NONCE_LO: nonce_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	actr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .restart(restart),
		.in_valid(data_valid), .in_ready(data_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .stat(stat)
	);

	actr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .restart(restart),
		.key_size(key_size_q), .key(key_q), .nonce(nonce_q),
		.data_byte(data_byte), .out_byte(out_byte),
		.cmd(cmd), .stat(stat)
	);

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
		else $error("output dropped under stall");
	a_no_take_on_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		$past(restart) |-> !data_ready) else $error("byte taken right after restart");
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(data_ready && out_valid) |-> out_ready) else $error("output overwritten");
`endif
endmodule

>>> hdl/actr_ctrl.sv
// controller state machine for block generation and byte handshake
module actr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output actr_pkg::ctl_cmd_t   cmd,
	input  actr_pkg::dp_stat_t   stat
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GEN  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0] state_q;
	logic [4:0] pos_q;
	logic       ov_q;
	logic       fire;

	assign in_ready = (state_q == ST_RUN) && !pos_q[4] && (!ov_q || out_ready);
	assign fire = in_valid && in_ready;
	assign out_valid = ov_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && pos_q[4] && in_valid && !restart;
		cmd.step = (state_q == ST_GEN);
		cmd.take = fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= 5'd16;
			ov_q <= 1'b0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (fire) ov_q <= 1'b1;
			if (restart) begin
				state_q <= ST_IDLE;
				pos_q <= 5'd16;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (cmd.load) state_q <= ST_GEN;
						else if (!pos_q[4]) state_q <= ST_RUN;
					end
					ST_GEN: begin
						if (stat.done) begin
							state_q <= ST_RUN;
							pos_q <= 5'd0;
						end
					end
					ST_RUN: begin
						if (fire) begin
							pos_q <= pos_q + 5'd1;
							if (pos_q == 5'd15) state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_no_take_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN) |-> !in_ready) else $error("byte taken during generation");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= 5'd16)) else $error("byte position out of range");
	a_ov_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid) else $error("result lost");
`endif
endmodule

>>> hdl/actr_dp.sv
// aes datapath: iterative key expansion, one round after every four key words, output byte
module actr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic [1:0]         key_size,
	input  logic [255:0]       key,
	input  logic [127:0]       nonce,
	input  logic [7:0]         data_byte,
	output logic [7:0]         out_byte,
	input  actr_pkg::ctl_cmd_t cmd,
	output actr_pkg::dp_stat_t stat
);
	// sliding window of the last nk key words, word 0 oldest
	logic [31:0]  win_q [8];
	logic [127:0] st_q;
	logic [127:0] ks_q;
	logic [31:0]  ctr_q;
	logic [3:0]   nk_q;
	logic [3:0]   nr_q;
	logic [3:0]   rnd_q;
	logic [2:0]   sub_q;     // key word within round
	logic [3:0]   ki_q;      // i mod nk
	logic [7:0]   rcon_q;
	logic [127:0] rk_q;      // round key collected so far
	logic [3:0]   byte_q;
	logic [7:0]   ob_q;
	logic [31:0]  nw;
	logic [31:0]  tmp;
	logic [127:0] rk_n;
	logic [1:0]   sel;
	logic [3:0]   nk_c;
	logic [3:0]   nk_m1;

	assign sel = (key_size == 2'd3) ? 2'd2 : key_size;
	assign nk_c = 4'd4 + {1'b0, sel, 1'b0};
	assign nk_m1 = nk_q - 4'd1;

	// next expanded word from the window
	always_comb begin
		tmp = win_q[nk_m1[2:0]];
		if (ki_q == 4'd0)
			tmp = {actr_pkg::sub_word({tmp[23:0], tmp[31:24]})} ^ {rcon_q, 24'h0};
		else if (nk_q > 4'd6 && ki_q == 4'd4)
			tmp = actr_pkg::sub_word(tmp);
		nw = win_q[0] ^ tmp;
		rk_n = {rk_q[95:0], nw};
	end

	// all nr rounds applied
	assign stat.done = (rnd_q == nr_q + 4'd1);
	assign out_byte = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			byte_q <= '0;
		end else if (restart) begin
			ctr_q <= '0;
			byte_q <= '0;
		end else begin
			if (cmd.load) ctr_q <= ctr_q + 32'd1;
			if (cmd.take) byte_q <= byte_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) ob_q <= data_byte ^ ks_q[127 - 8*byte_q -: 8];
		if (cmd.load) begin
			nk_q <= nk_c;
			nr_q <= nk_c + 4'd6;
			for (int i = 0; i < 8; i++)
				win_q[i] <= key[255 - 32*i -: 32];
			// round 0 uses key words 0..3 directly
			st_q <= (nonce ^ {96'h0, ctr_q}) ^ key[255:128];
			rcon_q <= 8'h01;
			ki_q <= (nk_c == 4'd4) ? 4'd0 : 4'd4;
			rnd_q <= 4'd1;
			sub_q <= 3'd0;
			rk_q <= key[255:128];
			// first words 4..nk-1 already in window: emit them without expansion
		end else if (cmd.step && !stat.done) begin
			if (sub_q == 3'd4) begin
				st_q <= actr_pkg::aes_round(st_q, rnd_q == nr_q) ^ rk_q;
				rnd_q <= rnd_q + 4'd1;
				sub_q <= 3'd0;
			end else begin
				if (rnd_q == 4'd1 && ki_q >= 4'd4) begin
					rk_q <= {rk_q[95:0], win_q[ki_q[2:0]]};
				end else begin
					rk_q <= rk_n;
					for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
					win_q[nk_m1[2:0]] <= nw;
					if (ki_q == 4'd0) rcon_q <= actr_pkg::xtime(rcon_q);
				end
				ki_q <= (ki_q + 4'd1 == nk_q) ? 4'd0 : ki_q + 4'd1;
				sub_q <= sub_q + 3'd1;
			end
		end
		if (stat.done && cmd.step) ks_q <= st_q;
	end

`ifndef SYNTHESIS
	a_nk_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (nk_q == 4'd4 || nk_q == 4'd6 || nk_q == 4'd8))
		else $error("bad key length");
	a_sub_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sub_q <= 3'd4) else $error("key word count overrun");
	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !restart) |=> ctr_q == $past(ctr_q) + 32'd1)
		else $error("counter not advanced");
`endif
endmodule
